// ===== src/linear_probe_hash_table_assert.svh =====
// Assertion macros for the RTL of the hash table.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hash table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hash table check failed");

`endif

// ===== src/lpht_pkg.sv =====
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int TableSize = 16;
  localparam int SlotW     = $clog2(TableSize);
  localparam int KeyW      = 31;
  localparam int OutSlotW  = 4;
  localparam int StatusW   = 2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  localparam logic [StatusW-1:0] ST_INSERTED  = 2'd0;
  localparam logic [StatusW-1:0] ST_FOUND     = 2'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_e;

endpackage

// ===== src/lpht_ram.sv =====
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/linear_probe_hash_table.sv =====
// Linear-probing hash table with 16 slots, keys of 31 bits.
// Request channel: mode_i (0 insert, 1 search) and key_i are taken at a rising
// edge where start is high and busy is low. busy stays high while the request
// walks the table.
// Result channel: done_o is high for exactly one cycle with status_o and slot_o.
// The receiver cannot hold results off; every request gives one result.
// The home slot is the key modulo 16. One slot is probed per cycle: the used
// flags sit in flip-flops and the keys in a RAM whose registered read is
// addressed one slot ahead of the compare.
// A request probes from its home slot until it finishes, and the result is
// then registered. A new request may be accepted in the cycle done_o is high.
// Reset clears every used flag, so the table starts empty; the key RAM is not
// cleared, since a key is only ever read from a slot that is marked used.
`timescale 1ns / 1ps

`include "linear_probe_hash_table_assert.svh"

module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                mode_i,
  input  logic [KeyW-1:0]     key_i,
  output logic                done_o,
  output logic [StatusW-1:0]  status_o,
  output logic [OutSlotW-1:0] slot_o
);

  state_e state_q, state_d;

  logic [TableSize-1:0] used_q, used_d;
  logic [SlotW-1:0]     s_q, s_d;
  logic [SlotW-1:0]     n_q, n_d;
  logic                 mode_q, mode_d;
  logic [KeyW-1:0]      key_q, key_d;
  logic                 done_q, done_d;
  logic [StatusW-1:0]   status_q, status_d;
  logic [OutSlotW-1:0]  slot_q, slot_d;

  logic             accept;
  logic             hit;
  logic             key_match;
  logic             last;
  logic             finish;
  logic [SlotW-1:0] home;
  logic [SlotW-1:0] s_next;
  logic [SlotW-1:0] raddr;
  logic             ram_we;
  logic [KeyW-1:0]  rdata;

  assign accept    = start && (state_q == S_IDLE);
  assign home      = SlotW'(key_i % TableSize);
  assign hit       = used_q[s_q];
  assign key_match = (rdata == key_q);
  assign last      = (n_q == SlotW'(TableSize - 1));
  assign s_next    = (s_q == SlotW'(TableSize - 1)) ? '0 : s_q + 1'b1;
  assign finish    = !hit || ((mode_q == MODE_SEARCH) && key_match) || last;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    s_d      = s_q;
    n_d      = n_q;
    mode_d   = mode_q;
    key_d    = key_q;
    used_d   = used_q;
    done_d   = 1'b0;
    status_d = status_q;
    slot_d   = slot_q;
    raddr    = s_next;
    ram_we   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        raddr = home;
        if (accept) begin
          s_d    = home;
          n_d    = '0;
          mode_d = mode_i;
          key_d  = key_i;
        end
      end
      S_PROBE: begin
        // The read issued last cycle holds the key of slot s_q now.
        s_d = s_next;
        n_d = n_q + 1'b1;
        if (finish) begin
          done_d = 1'b1;
          slot_d = '0;
        end
        priority if (!hit) begin
          if (mode_q == MODE_INSERT) begin
            ram_we      = 1'b1;
            used_d[s_q] = 1'b1;
            status_d    = ST_INSERTED;
            slot_d      = OutSlotW'(s_q);
          end else begin
            status_d = ST_NOT_FOUND;
          end
        end else if ((mode_q == MODE_SEARCH) && key_match) begin
          status_d = ST_FOUND;
          slot_d   = OutSlotW'(s_q);
        end else if (last) begin
          status_d = (mode_q == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
        end else begin
          status_d = status_q;
        end
      end
      default: begin
        raddr = home;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q      <= s_d;
    n_q      <= n_d;
    mode_q   <= mode_d;
    key_q    <= key_d;
    status_q <= status_d;
    slot_q   <= slot_d;
  end

  lpht_ram #(
    .Width (KeyW),
    .Depth (TableSize)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s_q),
    .wdata_i (key_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign slot_o   = slot_q;

  // A finished probe always yields a result word in the next cycle.
  `LPHT_ASSERT_NEXT(a_finish_done, (state_q == S_PROBE) && finish, done_o)
  // An accepted request always starts a probe.
  `LPHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // Each key write marks exactly one more slot as used.
  `LPHT_ASSERT_NEXT(a_insert_count, ram_we,
                    $countones(used_q) == $past($countones(used_q)) + 1)
  // The key RAM is never written outside a probe.
  `LPHT_ASSERT_NOW(a_idle_no_write, state_q == S_IDLE, !ram_we)

endmodule

// ===== dv/tb_linear_probe_hash_table.sv =====
`timescale 1ns / 1ps

module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  typedef struct {
    logic            mode;
    logic [KeyW-1:0] key;
    int unsigned     gap;
  } hash_req_t;

  typedef struct {
    logic [StatusW-1:0]  status;
    logic [OutSlotW-1:0] slot;
  } probe_outcome_t;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start  = 1'b0;
  logic                busy;
  logic                mode_i = MODE_INSERT;
  logic [KeyW-1:0]     key_i  = '0;
  logic                done_o;
  logic [StatusW-1:0]  status_o;
  logic [OutSlotW-1:0] slot_o;

  linear_probe_hash_table u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .mode_i  (mode_i),
    .key_i   (key_i),
    .done_o  (done_o),
    .status_o(status_o),
    .slot_o  (slot_o)
  );

  always #1 clk_i = ~clk_i;

  hash_req_t       req_queue[$];
  probe_outcome_t  probe_outcomes[$];
  logic [KeyW-1:0] known_keys[$];

  // Shadow copy of the table contents.
  logic            slot_taken[TableSize];
  logic [KeyW-1:0] stored_key[TableSize];

  logic word_taken = 1'b0;
  int   gap_left   = 0;
  int   fail_count = 0;
  int   accepted_cnt = 0;
  int   status_cnt[4];
  bit   no_gap_run = 1'b0;

  task automatic probe_table(input logic mode, input logic [KeyW-1:0] key,
                             output probe_outcome_t res);
    int unsigned idx;
    bit          stop;
    idx  = key % TableSize;
    stop = 1'b0;
    res.status = (mode == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
    res.slot   = '0;
    for (int n = 0; n < TableSize; n++) begin
      if (!stop) begin
        if (mode == MODE_INSERT) begin
          if (!slot_taken[idx]) begin
            slot_taken[idx] = 1'b1;
            stored_key[idx] = key;
            res.status      = ST_INSERTED;
            res.slot        = idx[OutSlotW-1:0];
            stop            = 1'b1;
          end
        end else begin
          if (!slot_taken[idx]) begin
            stop = 1'b1;
          end else if (stored_key[idx] == key) begin
            res.status = ST_FOUND;
            res.slot   = idx[OutSlotW-1:0];
            stop       = 1'b1;
          end
        end
        idx = (idx + 1) % TableSize;
      end
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if ($urandom_range(39) == 0) no_gap_run = ~no_gap_run;
    if (no_gap_run) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic add_req(input logic mode, input logic [KeyW-1:0] key);
    hash_req_t req;
    req.mode = mode;
    req.key  = key;
    req.gap  = pick_gap();
    req_queue.push_back(req);
    if (mode == MODE_INSERT) known_keys.push_back(key);
  endtask

  // Key with a chosen home slot and random upper bits.
  function automatic logic [KeyW-1:0] key_at_home(input int unsigned home);
    logic [KeyW-1:0] k;
    k = KeyW'($urandom());
    k[SlotW-1:0] = home[SlotW-1:0];
    return k;
  endfunction

  task automatic build_stimulus();
    int unsigned r;
    logic [KeyW-1:0] k;
    // Empty table, then the key extremes, a wrapping chain at the last slot,
    // duplicates, and misses that stop at an empty slot after a probe.
    add_req(MODE_SEARCH, '0);
    add_req(MODE_SEARCH, {KeyW{1'b1}});
    add_req(MODE_INSERT, '0);
    add_req(MODE_INSERT, {KeyW{1'b1}});
    add_req(MODE_INSERT, 31'd31);
    add_req(MODE_INSERT, 31'd15);
    add_req(MODE_SEARCH, 31'd15);
    add_req(MODE_SEARCH, 31'd31);
    add_req(MODE_SEARCH, 31'd47);
    add_req(MODE_INSERT, '0);
    add_req(MODE_SEARCH, '0);
    add_req(MODE_SEARCH, 31'h7FFF_FFF0);
    add_req(MODE_INSERT, 31'h5555_5555);
    add_req(MODE_INSERT, 31'h2AAA_AAAA);
    add_req(MODE_SEARCH, 31'h2AAA_AAAA);
    add_req(MODE_SEARCH, 31'h5555_5555);
    add_req(MODE_SEARCH, {KeyW{1'b1}});

    // Inserts are rare so the table fills partway through, leaving a long
    // stretch of full-table inserts and searches that walk every slot.
    for (int i = 0; i < 540; i++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        if ($urandom_range(3) == 0)
          k = known_keys[$urandom_range(known_keys.size() - 1)];
        else if ($urandom_range(1) == 0)
          k = key_at_home($urandom_range(3));
        else
          k = KeyW'($urandom());
        add_req(MODE_INSERT, k);
      end else if (r < 6) begin
        add_req(MODE_INSERT, KeyW'($urandom()));
      end else if (r < 60) begin
        add_req(MODE_SEARCH, known_keys[$urandom_range(known_keys.size() - 1)]);
      end else if (r < 85) begin
        add_req(MODE_SEARCH, key_at_home($urandom_range(TableSize - 1)));
      end else begin
        add_req(MODE_SEARCH, KeyW'($urandom()));
      end
    end
  endtask

  always @(negedge clk_i) begin : drive
    hash_req_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_queue.size() > 0) begin
        nxt      = req_queue.pop_front();
        start    <= 1'b1;
        mode_i   <= nxt.mode;
        key_i    <= nxt.key;
        gap_left <= nxt.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch
    probe_outcome_t want;
    probe_outcome_t next_want;
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      if (done_o) begin
        if (probe_outcomes.size() == 0) begin
          $display("%0t: result with nothing outstanding, status %0d slot %0d",
                   $time, status_o, slot_o);
          fail_count++;
        end else begin
          want = probe_outcomes.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, status_o);
            fail_count++;
          end
          if (slot_o !== want.slot) begin
            $display("%0t: slot mismatch, expected %0d actual %0d",
                     $time, want.slot, slot_o);
            fail_count++;
          end
          status_cnt[want.status]++;
        end
      end
      if (start && !busy) begin
        probe_table(mode_i, key_i, next_want);
        probe_outcomes.push_back(next_want);
        accepted_cnt++;
      end
      word_taken <= start && !busy;
    end
  end

  initial begin
    for (int i = 0; i < TableSize; i++) begin
      slot_taken[i] = 1'b0;
      stored_key[i] = '0;
    end
    for (int i = 0; i < 4; i++) status_cnt[i] = 0;
    build_stimulus();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (req_queue.size() == 0 && !start);
    wait (probe_outcomes.size() == 0);
    repeat (40) @(posedge clk_i);
    $display("Ran %0d requests: %0d inserted, %0d found, %0d not found, %0d full.",
             accepted_cnt, status_cnt[ST_INSERTED], status_cnt[ST_FOUND],
             status_cnt[ST_NOT_FOUND], status_cnt[ST_FULL]);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("Timed out with %0d requests pending and %0d results outstanding.",
             req_queue.size(), probe_outcomes.size());
    $display("tb: failure");
    $finish;
  end

endmodule
